/* sv/gff_pkg.sv */
// Shared constants, types and helpers for the Gaussian form factor pipeline.
package gff_pkg;

  // 1/(4*pi), log2(e), ln(2) with 32 fraction bits; pi/2 with 31
  localparam logic [31:0] KINV4PI = 32'd341782638;
  localparam logic [32:0] LOG2E   = 33'd6196328019;
  localparam logic [31:0] LN2     = 32'd2977044472;
  localparam logic [31:0] HALFPI  = 32'd3373259426;

  localparam logic [63:0]        EXP_LIM   = 64'h2000_0000_0000_0000;
  localparam logic signed [63:0] EXP_CLAMP = 64'sh0000_0080_0000_0000;
  localparam logic [62:0]        AMP_MAX   = '1;
  localparam int                 OUT_FRAC  = 24;

  // series datapath widths
  localparam int SER_DW = 34;   // dividend after product shift
  localparam int SER_TW = 33;   // term
  localparam int SER_OW = 32;   // series argument
  localparam int SER_AW = 36;   // signed accumulators

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_CUTOFF = 2'd2
  } cfg_reg_t;

  // magnitude of a 32-bit two's complement value
  function automatic logic [31:0] mag32(input logic [31:0] v);
    logic [32:0] d;
    d = 33'h1_0000_0000 - {1'b0, v};
    return v[31] ? d[31:0] : v;
  endfunction

endpackage

/* sv/gaussian_form_factor_eval_core.sv */
// Gaussian form factor evaluator: 42-stage pipeline from q point to complex result.
//
// Usage:
//   Raise start with qx_real, qy_real, qz_real, qz_imag valid; the item is
//   taken at that edge. busy is high only during reset, so one q point can
//   enter every cycle.
//   Each result leaves the pipeline with result_valid high
//   for one cycle with result_real, result_imag (signed Q40.24) and saturated.
//   Results come out in order, one per item, exactly one clock each; the
//   receiver must take them when shown, it cannot stall the pipeline.
//   Most of the pipeline is the two power series: 13 exp terms and 16 cos/sin terms,
//   each term one multiply stage plus one reciprocal divide stage.
//   Throughput is one item per cycle.
//   Configuration: cfg_valid/cfg_ready with cfg_index (0 width, 1 height,
//   2 cutoff) and cfg_data; cfg_ready is always high. Write only while no item
//   is in flight.
//   Reset (rst, synchronous) empties the pipeline and sets width = height = 1.0
//   and cutoff to its default.
module gaussian_form_factor_eval_core
  import gff_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] qx_real,
  input  logic signed [31:0] qy_real,
  input  logic signed [31:0] qz_real,
  input  logic signed [31:0] qz_imag,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               result_valid,
  output logic signed [63:0] result_real,
  output logic signed [63:0] result_imag,
  output logic               saturated
);

  localparam int GSH      = 2 * FRAC_BITS - 16;
  localparam int PI_RSH   = (2 * FRAC_BITS + 1 >= 32) ? 2 * FRAC_BITS + 1 - 32 : 0;
  localparam int PI_LSH   = (2 * FRAC_BITS + 1 >= 32) ? 0 : 31 - 2 * FRAC_BITS;
  localparam int TURN_LSB = 2 * FRAC_BITS;
  localparam int AMP_BIAS = 3 * FRAC_BITS + 32 - OUT_FRAC;
  localparam int PW       = 98;

  // ---------------- configuration ----------------
  logic [31:0] width;
  logic [31:0] height;
  logic [31:0] cutoff;

  assign cfg_ready = 1'b1;
  assign busy      = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= 32'(1) << FRAC_BITS;
      height <= 32'(1) << FRAC_BITS;
      cutoff <= 32'd805240;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIDTH:  width  <= cfg_data;
        REG_HEIGHT: height <= cfg_data;
        REG_CUTOFF: cutoff <= cfg_data;
        default: ;
      endcase
    end
  end

  // width^2*height, normalized to 64 bits; settles long before stage 38 needs it
  logic [63:0] w2;
  logic [63:0] hp_lo;
  logic [63:0] hp_hi;
  logic [95:0] wwh;
  logic [95:0] wwh_q;
  logic [5:0]  adj_c;
  logic [5:0]  adj_q;
  logic [63:0] m1;

  always_comb begin
    adj_c = '0;
    for (int i = 0; i < 32; i++) begin
      if (wwh[64+i]) adj_c = 6'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    w2    <= 64'(width) * 64'(width);
    hp_lo <= 64'(w2[31:0]) * 64'(height);
    hp_hi <= 64'(w2[63:32]) * 64'(height);
    wwh   <= 96'(hp_lo) + (96'(hp_hi) << 32);
    wwh_q <= wwh;
    adj_q <= adj_c;
    m1    <= 64'(wwh_q >> adj_q);
  end

  // ---------------- valid chain ----------------
  logic [41:1] v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v            <= '0;
      result_valid <= 1'b0;
    end else begin
      v            <= {v[40:1], start && !busy};
      result_valid <= v[41];
    end
  end

  // ---------------- front end: stages 1..11 ----------------
  logic [31:0] qx_s1, qy_s1, qz_s1, qi_s1;
  logic [63:0] px_s2, py_s2, pz_s2, pi_s2;
  logic        nz_s2, ni_s2;
  logic        cut_s3, nz_s3, ni_s3;
  logic [31:0] sx_s3, sy_s3, sz_s3;
  logic [63:0] pic_s3, tlo_s3, thi_s3;
  logic [63:0] ssx_s4, ssy_s4, ssz_s4, pic_s4;
  logic [31:0] turns_s4;
  logic        ni_s4;
  logic [63:0] glx_s5, gly_s5, glz_s5, ghx_s5, ghy_s5, ghz_s5, pic_s5;
  logic [31:0] a_s5;
  logic [1:0]  quad_s5;
  logic        ni_s5;
  logic [63:0] gx_s6, gy_s6, gz_s6, pic_s6;
  logic        ni_s6;
  logic [63:0] g_s7;
  logic signed [63:0] b_s7;
  logic signed [63:0] e_s8;
  logic [64:0] xl_s9;
  logic [40:0] xh_s9;
  logic        xneg_s9;
  logic [31:0] f_s10;
  logic signed [9:0] n_s10;
  logic [31:0] y_s11;

  logic [63:0] lim;
  logic [63:0] pis;
  logic [95:0] tsum;
  logic [31:0] turn_raw;
  logic [63:0] gsum;
  logic signed [63:0] esum;
  logic [39:0] xabs;
  logic [41:0] tm;
  logic [9:0]  tmi;

  function automatic logic [31:0] clamp32(input logic [63:0] p);
    logic [63:0] s;
    s = p >> GSH;
    return (s[63:32] != '0) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  assign lim      = 64'(cutoff) << FRAC_BITS;
  assign pis      = pi_s2 >> PI_RSH;
  assign tsum     = 96'(tlo_s3) + (96'(thi_s3) << 32);
  assign turn_raw = tsum[TURN_LSB +: 32];
  assign gsum     = gx_s6 + gy_s6 + gz_s6;
  assign esum     = $signed(g_s7) + b_s7;
  assign xabs     = e_s8[63] ? 40'(-e_s8) : 40'(e_s8);
  assign tm       = 42'(xh_s9) + 42'(xl_s9 >> 32);
  assign tmi      = tm[41:32];

  always_ff @(posedge clk) begin
    qx_s1 <= qx_real;
    qy_s1 <= qy_real;
    qz_s1 <= qz_real;
    qi_s1 <= qz_imag;

    px_s2 <= 64'(mag32(qx_s1)) * 64'(width);
    py_s2 <= 64'(mag32(qy_s1)) * 64'(width);
    pz_s2 <= 64'(mag32(qz_s1)) * 64'(height);
    pi_s2 <= 64'(mag32(qi_s1)) * 64'(height);
    nz_s2 <= qz_s1[31];
    ni_s2 <= qi_s1[31];

    cut_s3 <= (px_s2 > lim) || (py_s2 > lim) || (pz_s2 > lim);
    sx_s3  <= clamp32(px_s2);
    sy_s3  <= clamp32(py_s2);
    sz_s3  <= clamp32(pz_s2);
    pic_s3 <= (pis > (EXP_LIM >> PI_LSH)) ? EXP_LIM : (pis << PI_LSH);
    tlo_s3 <= 64'(pz_s2[31:0]) * 64'(KINV4PI);
    thi_s3 <= 64'(pz_s2[63:32]) * 64'(KINV4PI);
    nz_s3  <= nz_s2;
    ni_s3  <= ni_s2;

    ssx_s4   <= 64'(sx_s3) * 64'(sx_s3);
    ssy_s4   <= 64'(sy_s3) * 64'(sy_s3);
    ssz_s4   <= 64'(sz_s3) * 64'(sz_s3);
    turns_s4 <= nz_s3 ? (32'd0 - turn_raw) : turn_raw;
    pic_s4   <= pic_s3;
    ni_s4    <= ni_s3;

    glx_s5  <= 64'(ssx_s4[31:0]) * 64'(KINV4PI);
    gly_s5  <= 64'(ssy_s4[31:0]) * 64'(KINV4PI);
    glz_s5  <= 64'(ssz_s4[31:0]) * 64'(KINV4PI);
    ghx_s5  <= 64'(ssx_s4[63:32]) * 64'(KINV4PI);
    ghy_s5  <= 64'(ssy_s4[63:32]) * 64'(KINV4PI);
    ghz_s5  <= 64'(ssz_s4[63:32]) * 64'(KINV4PI);
    a_s5    <= 32'((64'(turns_s4[29:0]) * 64'(HALFPI)) >> 30);
    quad_s5 <= turns_s4[31:30];
    pic_s5  <= pic_s4;
    ni_s5   <= ni_s4;

    gx_s6  <= ghx_s5 + (glx_s5 >> 32);
    gy_s6  <= ghy_s5 + (gly_s5 >> 32);
    gz_s6  <= ghz_s5 + (glz_s5 >> 32);
    pic_s6 <= pic_s5;
    ni_s6  <= ni_s5;

    // three terms add modulo 2^64, then clamp
    g_s7 <= (gsum > EXP_LIM) ? EXP_LIM : gsum;
    b_s7 <= ni_s6 ? -$signed(pic_s6) : $signed(pic_s6);

    if (esum > EXP_CLAMP) begin
      e_s8 <= EXP_CLAMP;
    end else if (esum < -EXP_CLAMP) begin
      e_s8 <= -EXP_CLAMP;
    end else begin
      e_s8 <= esum;
    end

    // x = -e, so x is negative when e is positive
    xneg_s9 <= !e_s8[63] && (e_s8 != '0);
    xl_s9   <= 65'(xabs[31:0]) * 65'(LOG2E);
    xh_s9   <= 41'(xabs[39:32]) * 41'(LOG2E);

    f_s10 <= xneg_s9 ? (32'd0 - tm[31:0]) : tm[31:0];
    n_s10 <= xneg_s9 ? ($signed(-tmi) - ((tm[31:0] != '0) ? 10'sd1 : 10'sd0))
                     : $signed(tmi);

    y_s11 <= 32'((64'(f_s10) * 64'(LN2)) >> 32);
  end

  // ---------------- series: exp (11..37), cos/sin (5..37) ----------------
  logic signed [SER_AW-1:0] mant_s37;
  logic signed [SER_AW-1:0] c_s37;
  logic signed [SER_AW-1:0] s_s37;

  gff_series #(.NTERMS(13), .SHIFT(32), .TRIG(1'b0)) u_exp (
    .clk   (clk),
    .op    (y_s11),
    .acc_a (mant_s37),
    .acc_b ()
  );

  gff_series #(.NTERMS(16), .SHIFT(31), .TRIG(1'b1)) u_trig (
    .clk   (clk),
    .op    (a_s5),
    .acc_a (c_s37),
    .acc_b (s_s37)
  );

  logic [9:0] n_s37_u;
  logic [1:0] quad_s37;
  logic       cut_s41;

  gff_delay #(.W(10), .D(27)) u_dly_n (
    .clk (clk), .d (n_s10), .q (n_s37_u)
  );
  gff_delay #(.W(2), .D(32)) u_dly_quad (
    .clk (clk), .d (quad_s5), .q (quad_s37)
  );
  gff_delay #(.W(1), .D(38)) u_dly_cut (
    .clk (clk), .d (cut_s3), .q (cut_s41)
  );

  // ---------------- back end: stages 38..42 ----------------
  function automatic logic signed [32:0] clamp_q31(input logic signed [SER_AW-1:0] x);
    logic signed [SER_AW-1:0] one;
    one = $signed(SER_AW'(1) << 31);
    if (x > one) return $signed(33'(1) << 31);
    if (x < -one) return -$signed(33'(1) << 31);
    return 33'(x);
  endfunction

  logic signed [32:0] cc, sc;
  logic [65:0]        pa_s38, pb_s38;
  logic signed [10:0] r_s38, r_s39;
  logic signed [32:0] cv_s38, sv_s38, cv_s39, sv_s39, cv_s40, sv_s40;
  logic [PW-1:0]      p_s39;
  logic [62:0]        amp_c, amp_s40;
  logic               sat_c, sat_s40, sat_s41;
  logic [PW-1:0]      vsh;
  logic [10:0]        lsh;
  logic [63:0]        al_s41, ah_s41, bl_s41, bh_s41;
  logic               cneg_s41, sneg_s41;
  logic [31:0]        cabs, sabs;
  logic [63:0]        mre, mim;

  assign cc = clamp_q31(c_s37);
  assign sc = clamp_q31(s_s37);

  always_comb begin
    vsh   = '0;
    amp_c = '0;
    sat_c = 1'b0;
    lsh   = 11'(-r_s39);
    if (!r_s39[10]) begin
      if ($unsigned(r_s39) < 11'(PW)) vsh = p_s39 >> $unsigned(r_s39);
      sat_c = (vsh[PW-1:63] != '0);
      amp_c = sat_c ? AMP_MAX : vsh[62:0];
    end else if (p_s39 != '0) begin
      if (lsh >= 11'd63) begin
        sat_c = 1'b1;
      end else begin
        vsh   = p_s39 >> (11'd63 - lsh);
        sat_c = (vsh != '0);
      end
      amp_c = sat_c ? AMP_MAX : (p_s39[62:0] << lsh);
    end
  end

  assign cabs = cv_s40[32] ? 32'(-cv_s40) : 32'(cv_s40);
  assign sabs = sv_s40[32] ? 32'(-sv_s40) : 32'(sv_s40);
  assign mre  = (ah_s41 << 1) + (al_s41 >> 31);
  assign mim  = (bh_s41 << 1) + (bl_s41 >> 31);

  always_ff @(posedge clk) begin
    pa_s38 <= 66'(m1[31:0]) * 66'(mant_s37[33:0]);
    pb_s38 <= 66'(m1[63:32]) * 66'(mant_s37[33:0]);
    r_s38  <= 11'(AMP_BIAS) - 11'(adj_q) - 11'($signed(n_s37_u));
    unique case (quad_s37)
      2'd0: begin cv_s38 <= cc;  sv_s38 <= sc;  end
      2'd1: begin cv_s38 <= -sc; sv_s38 <= cc;  end
      2'd2: begin cv_s38 <= -cc; sv_s38 <= -sc; end
      default: begin cv_s38 <= sc; sv_s38 <= -cc; end
    endcase

    p_s39  <= PW'(pa_s38) + (PW'(pb_s38) << 32);
    r_s39  <= r_s38;
    cv_s39 <= cv_s38;
    sv_s39 <= sv_s38;

    amp_s40 <= amp_c;
    sat_s40 <= sat_c;
    cv_s40  <= cv_s39;
    sv_s40  <= sv_s39;

    al_s41   <= 64'(amp_s40[31:0]) * 64'(cabs);
    ah_s41   <= 64'(amp_s40[62:32]) * 64'(cabs);
    bl_s41   <= 64'(amp_s40[31:0]) * 64'(sabs);
    bh_s41   <= 64'(amp_s40[62:32]) * 64'(sabs);
    cneg_s41 <= cv_s40[32];
    sneg_s41 <= sv_s40[32];
    sat_s41  <= sat_s40;

    result_real <= cut_s41 ? '0 : $signed(cneg_s41 ? (64'd0 - mre) : mre);
    result_imag <= cut_s41 ? '0 : $signed(sneg_s41 ? (64'd0 - mim) : mim);
    saturated   <= v[41] && !cut_s41 && sat_s41;
  end

  // ---------------- assertions ----------------
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##42 result_valid)
    else $error("item did not come out after 42 cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start, 42))
    else $error("result without a matching item");

  a_cut_zero: assert property (@(posedge clk) disable iff (rst)
    v[41] && cut_s41 |=> result_real == '0 && result_imag == '0 && !saturated)
    else $error("cutoff item gave a nonzero result");

  a_sat_valid: assert property (@(posedge clk) disable iff (rst)
    saturated |-> result_valid)
    else $error("saturated flag outside a result");

endmodule

/* sv/gff_delay.sv */
// Fixed-depth delay line for side-band fields.
module gff_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe [D];

  always_ff @(posedge clk) begin
    pipe[0] <= d;
    for (int i = 1; i < D; i++) begin
      pipe[i] <= pipe[i-1];
    end
  end

  assign q = pipe[D-1];

endmodule

/* sv/gff_series.sv */
// Pipelined power series: per term one multiply stage and one exact divide-by-k stage.
module gff_series
  import gff_pkg::*;
#(
  parameter int NTERMS = 13,
  parameter int SHIFT  = 32,
  parameter bit TRIG   = 1'b0
) (
  input  logic                     clk,
  input  logic [SER_OW-1:0]        op,
  output logic signed [SER_AW-1:0] acc_a,
  output logic signed [SER_AW-1:0] acc_b
);

  localparam logic [SER_TW-1:0] ONE = SER_TW'(1) << SHIFT;

  logic [SER_DW-1:0]        xa   [1:NTERMS];
  logic [SER_OW-1:0]        opa  [1:NTERMS];
  logic [SER_OW-1:0]        opb  [1:NTERMS];
  logic [SER_TW-1:0]        tb   [1:NTERMS];
  logic signed [SER_AW-1:0] sa_a [1:NTERMS];
  logic signed [SER_AW-1:0] sa_b [1:NTERMS];
  logic signed [SER_AW-1:0] sb_a [1:NTERMS];
  logic signed [SER_AW-1:0] sb_b [1:NTERMS];

  for (genvar k = 1; k <= NTERMS; k++) begin : g_step
    // exact reciprocal for any SER_DW-bit dividend
    localparam int L = $clog2(k);
    localparam logic [71:0] MAGIC72 =
      ((72'd1 << (SER_DW + L)) + 72'(k) - 72'd1) / 72'(k);
    localparam logic [SER_DW+1:0] MAGIC = MAGIC72[SER_DW+1:0];

    logic [SER_TW-1:0]        t_in;
    logic [SER_OW-1:0]        o_in;
    logic signed [SER_AW-1:0] ia;
    logic signed [SER_AW-1:0] ib;
    logic [SER_TW+SER_OW-1:0] prod;
    logic [2*SER_DW+1:0]      qprod;
    logic [SER_TW-1:0]        q;
    logic signed [SER_AW-1:0] qs;

    if (k == 1) begin : g_first
      assign t_in = ONE;
      assign o_in = op;
      assign ia   = $signed(SER_AW'(ONE));
      assign ib   = '0;
    end else begin : g_next
      assign t_in = tb[k-1];
      assign o_in = opb[k-1];
      assign ia   = sb_a[k-1];
      assign ib   = sb_b[k-1];
    end

    assign prod  = (SER_TW+SER_OW)'(t_in) * (SER_TW+SER_OW)'(o_in);
    assign qprod = (2*SER_DW+2)'(xa[k]) * (2*SER_DW+2)'(MAGIC);
    assign q     = SER_TW'(qprod >> (SER_DW + L));
    assign qs    = $signed({{(SER_AW-SER_TW){1'b0}}, q});

    always_ff @(posedge clk) begin
      xa[k]   <= SER_DW'(prod >> SHIFT);
      opa[k]  <= o_in;
      sa_a[k] <= ia;
      sa_b[k] <= ib;
    end

    always_ff @(posedge clk) begin
      tb[k]  <= q;
      opb[k] <= opa[k];
      if (!TRIG || k % 4 == 0) begin
        sb_a[k] <= sa_a[k] + qs;
        sb_b[k] <= sa_b[k];
      end else if (k % 4 == 1) begin
        sb_a[k] <= sa_a[k];
        sb_b[k] <= sa_b[k] + qs;
      end else if (k % 4 == 2) begin
        sb_a[k] <= sa_a[k] - qs;
        sb_b[k] <= sa_b[k];
      end else begin
        sb_a[k] <= sa_a[k];
        sb_b[k] <= sa_b[k] - qs;
      end
    end
  end

  assign acc_a = sb_a[NTERMS];
  assign acc_b = sb_b[NTERMS];

endmodule
